// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the convex hull trick DP block.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned HullDepthDef = 4096;
  localparam int unsigned CoordW       = 20;
  localparam int unsigned CostW        = 62;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 64;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_SAT  = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_WAIT,
    S_POP_MUL,
    S_POP_CMP,
    S_PUSH,
    S_SRCH_RD,
    S_SRCH_WAIT,
    S_SRCH_MUL,
    S_SRCH_CMP,
    S_EVAL_RD,
    S_EVAL_WAIT,
    S_EVAL_MUL,
    S_EVAL_ADD,
    S_OUT
  } cht_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture input item, clear hull on start
    logic pop_rd;      // read top two hull entries
    logic pop_part;    // low halves of the cross products
    logic pop_mul;     // add high halves of the cross products
    logic pop_cmp;     // pop decision is applied
    logic push;        // write new line
    logic srch_init;   // start binary search
    logic srch_rd;     // read lines mid and mid+1
    logic srch_mul;    // form breakpoint product
    logic srch_cmp;    // update search bounds
    logic eval_rd;     // read chosen line
    logic eval_mul;    // slope times width
    logic eval_add;    // add intercept, saturate, load output
  } cht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_pop;     // at least two lines
    logic pop_ok;      // pop test holds
    logic srch_done;   // lo == hi
  } cht_sts_t;

endpackage

// ===== rtl/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-port-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  // write port and two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer: pop loop, push, binary search, evaluation, output hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  input  cht_pkg::cht_sts_t sts,
  output cht_pkg::cht_cmd_t cmd,
  output logic              busy
);
  import cht_pkg::*;

  cht_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    cmd.load_item = in_fire;
    case (state_r)
      S_IDLE:      if (in_fire) state_nxt = S_POP_RD;
      S_POP_RD: begin
        if (sts.can_pop) begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_WAIT;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      // read addresses held so the data stays put for the second half
      S_POP_WAIT: begin
        cmd.pop_rd   = 1'b1;
        cmd.pop_part = 1'b1;
        state_nxt    = S_POP_MUL;
      end
      S_POP_MUL: begin
        cmd.pop_mul = 1'b1;
        state_nxt   = S_POP_CMP;
      end
      S_POP_CMP: begin
        cmd.pop_cmp = 1'b1;
        state_nxt   = sts.pop_ok ? S_POP_RD : S_PUSH;
      end
      S_PUSH: begin
        cmd.push      = 1'b1;
        cmd.srch_init = 1'b1;
        state_nxt     = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (sts.srch_done) begin
          state_nxt = S_EVAL_RD;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_WAIT;
        end
      end
      S_SRCH_WAIT: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = S_SRCH_MUL;
      end
      S_SRCH_MUL: begin
        cmd.srch_mul = 1'b1;
        state_nxt    = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = S_SRCH_RD;
      end
      S_EVAL_RD: begin
        cmd.eval_rd = 1'b1;
        state_nxt   = S_EVAL_WAIT;
      end
      S_EVAL_WAIT: begin
        cmd.eval_rd = 1'b1;
        state_nxt   = S_EVAL_MUL;
      end
      S_EVAL_MUL: begin
        cmd.eval_mul = 1'b1;
        state_nxt    = S_EVAL_ADD;
      end
      S_EVAL_ADD:  if (out_free) state_nxt = S_OUT;
      S_OUT: begin
        cmd.eval_add = 1'b1;
        state_nxt    = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/cht_dp.sv =====
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: hull memories, pop test, breakpoint search and line evaluation.
// ----------------------------------------------------------------------------
module cht_dp #(
  parameter int unsigned HullDepth = cht_pkg::HullDepthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cht_pkg::cht_cmd_t           cmd,
  input  logic                        in_start_req,
  input  logic [cht_pkg::CoordW-1:0]  in_width,
  input  logic [cht_pkg::CoordW-1:0]  in_height,
  output cht_pkg::cht_sts_t           sts,
  output logic [cht_pkg::CostW-1:0]   res_cost,
  output logic [cht_pkg::StatusW-1:0] res_status
);
  import cht_pkg::*;

  localparam int unsigned AW = (HullDepth > 1) ? $clog2(HullDepth) : 1;
  localparam int unsigned CW = $clog2(HullDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(HullDepth);
  localparam int unsigned DW = CostW + 1;   // signed difference
  localparam int unsigned KW = CoordW + 1;  // signed slope difference
  localparam int unsigned PW = DW + KW;
  localparam int unsigned HW = DW - 32;     // upper part of a cost difference

  logic [CW-1:0]      cnt_r;
  logic [CostW-1:0]   prev_r;
  logic [CoordW-1:0]  x_r, kn_r;
  logic [CostW-1:0]   bn_r;
  logic               full_r;
  logic [CW-1:0]      lo_r, hi_r;
  logic [CW-1:0]      mid;
  logic               cmp_ge;
  logic [PW-1:0]      lhs_r, rhs_r;
  logic [CostW+CoordW-1:0] prod_r;
  logic [AW-1:0]      ra, rb, wa;
  logic [CoordW-1:0]  ka, kb;
  logic [CostW-1:0]   ba, bb;
  logic               we;

  logic signed [DW-1:0]    d_tp, d_nt, d_b;
  logic signed [KW-1:0]    d_tn, d_pt, d_k;
  logic signed [32:0]      tp_lo, nt_lo;
  logic signed [HW-1:0]    tp_hi, nt_hi;
  logic signed [KW+32:0]   pl_lo, pr_lo;
  logic signed [HW+KW-1:0] pl_hi, pr_hi;
  logic signed [2*KW-1:0]  p_x;

  logic [CoordW-1:0]       kb_sel;
  logic [CostW+CoordW:0]   sum;
  logic [CostW-1:0]        res_cost_nxt;
  logic [StatusW-1:0]      res_status_nxt;
  logic [CostW-1:0]        ba_q;

  // hull storage: entry a and entry b = a+1
  assign we = cmd.push && (cnt_r < DepthC);
  assign wa = cnt_r[AW-1:0];
  cht_ram #(.Width(CoordW), .Depth(HullDepth)) u_slopes (
    .clk(clk), .we(we), .waddr(wa), .wdata(kn_r),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(ka), .rdata_b(kb));
  cht_ram #(.Width(CostW), .Depth(HullDepth)) u_icpts (
    .clk(clk), .we(we), .waddr(wa), .wdata(bn_r),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(ba), .rdata_b(bb));

  // read address selection, held over the wait cycle
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  always_comb begin
    ra = '0;
    rb = '0;
    if (cmd.pop_rd) begin
      ra = AW'(cnt_r - CW'(2));
      rb = AW'(cnt_r - CW'(1));
    end else if (cmd.srch_rd) begin
      ra = mid[AW-1:0];
      rb = AW'(mid + CW'(1));
    end else if (cmd.eval_rd) begin
      ra = lo_r[AW-1:0];
    end
  end

  // signed differences and products
  assign d_tp = $signed({1'b0, bb}) - $signed({1'b0, ba});
  assign d_nt = $signed({1'b0, bn_r}) - $signed({1'b0, bb});
  assign d_tn = $signed({1'b0, kb}) - $signed({1'b0, kn_r});
  assign d_pt = $signed({1'b0, ka}) - $signed({1'b0, kb});
  assign d_b  = d_tp;
  assign d_k  = d_pt;

  // cross products in two halves: low 32 bits of the cost difference first
  assign tp_lo = $signed({1'b0, d_tp[31:0]});
  assign tp_hi = $signed(d_tp[DW-1:32]);
  assign nt_lo = $signed({1'b0, d_nt[31:0]});
  assign nt_hi = $signed(d_nt[DW-1:32]);
  assign pl_lo = tp_lo * d_tn;
  assign pl_hi = tp_hi * d_tn;
  assign pr_lo = nt_lo * d_pt;
  assign pr_hi = nt_hi * d_pt;
  assign p_x   = $signed({1'b0, x_r}) * d_k;

  // control registers and item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      prev_r <= '0;
      full_r <= 1'b0;
      lo_r   <= '0;
      hi_r   <= '0;
    end else begin
      if (cmd.load_item) begin
        x_r    <= in_width;
        kn_r   <= in_height;
        bn_r   <= in_start_req ? '0 : prev_r;
        full_r <= 1'b0;
        if (in_start_req) begin
          cnt_r <= '0;
        end
      end
      if (cmd.pop_cmp && cmp_ge) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.push) begin
        if (cnt_r < DepthC) begin
          cnt_r <= cnt_r + CW'(1);
          hi_r  <= cnt_r;
        end else begin
          full_r <= 1'b1;
          hi_r   <= cnt_r - CW'(1);
        end
      end
      if (cmd.srch_init) begin
        lo_r <= '0;
      end
      if (cmd.srch_cmp) begin
        if (cmp_ge) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + CW'(1);
        end
      end
      if (cmd.eval_add) begin
        prev_r <= res_cost_nxt;
      end
    end
  end

  // product and decision registers
  always_ff @(posedge clk) begin
    if (cmd.pop_part) begin
      lhs_r <= PW'(pl_lo);
      rhs_r <= PW'(pr_lo);
    end
    if (cmd.pop_mul) begin
      lhs_r <= lhs_r + (PW'(pl_hi) <<< 32);
      rhs_r <= rhs_r + (PW'(pr_hi) <<< 32);
    end
    if (cmd.srch_mul) begin
      lhs_r <= PW'(d_b);
      rhs_r <= PW'(p_x);
    end
    if (cmd.eval_mul) begin
      prod_r <= kb_sel * x_r;
    end
  end
  assign kb_sel = ka;
  assign cmp_ge = ($signed(lhs_r) >= $signed(rhs_r));

  // evaluation and saturation
  always_ff @(posedge clk) begin
    if (cmd.eval_mul) begin
      ba_q <= ba;
    end
  end
  assign sum = {1'b0, prod_r} + (CostW+CoordW+1)'(ba_q);
  always_comb begin
    res_cost_nxt   = sum[CostW-1:0];
    res_status_nxt = full_r ? ST_FULL : ST_OK;
    if (sum > (CostW+CoordW+1)'(CostMax)) begin
      res_cost_nxt = CostMax;
      if (!full_r) begin
        res_status_nxt = ST_SAT;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.eval_add) begin
      res_cost   <= res_cost_nxt;
      res_status <= res_status_nxt;
    end
  end

  assign sts.can_pop   = (cnt_r >= CW'(2));
  assign sts.pop_ok    = cmp_ge;
  assign sts.srch_done = (lo_r == hi_r);

endmodule

// ===== rtl/convex_hull_trick_min_dp.sv =====
// ----------------------------------------------------------------------------
// convex_hull_trick_min_dp
// Convex hull trick for the land acquisition DP, one cost out per rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries {height, width}, in_tuser carries start_req. Set
//   start_req on the first rectangle of a sequence to empty the hull.
//   out_tdata carries {status, min_cost}; one result per input transfer.
//   out_tvalid rises after the input transfer, the pop phase, the push,
//   the search steps (about log2 of the hull size, 12 at most) and the
//   evaluation. The pop phase runs one pop test per popped line plus the
//   failing test, or ends when fewer than two lines remain. Each pop test
//   and search step reads the hull RAM, waits for the read data, then
//   passes a multiply and a compare stage. The next transfer can be
//   accepted as soon as out_tvalid rises.
//   Items are processed one at a time; in_tready is high while idle.
//   A result is held in the output register until taken; the next item
//   may be accepted while it waits, and its result is not loaded until the
//   output register is free, so a stalled receiver adds its stall cycles.
//   Reset (rst_n low, synchronous) empties the hull and zeroes the
//   previous cost; no clearing pass is needed.
// ----------------------------------------------------------------------------
module convex_hull_trick_min_dp #(
  parameter int unsigned HullDepth = cht_pkg::HullDepthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [cht_pkg::InDataW-1:0]  in_tdata,  // width[19:0], height[39:20]
  input  logic                         in_tuser,  // start_req
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [cht_pkg::OutDataW-1:0] out_tdata  // min_cost[61:0], status[63:62]
);
  import cht_pkg::*;

  cht_cmd_t           cmd;
  cht_sts_t           sts;
  logic               busy, in_fire, out_free;
  logic               ovalid_r;
  logic [CostW-1:0]   cost;
  logic [StatusW-1:0] status;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;

  cht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy));

  cht_dp #(.HullDepth(HullDepth)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_start_req(in_tuser),
    .in_width(in_tdata[CoordW-1:0]),
    .in_height(in_tdata[2*CoordW-1:CoordW]),
    .sts(sts), .res_cost(cost), .res_status(status));

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.eval_add) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {status, cost};

endmodule

// ===== rtl/cht_checker.sv =====
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the convex hull trick block.
// ----------------------------------------------------------------------------
module cht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // no new item accepted in the cycle after one
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("back-to-back accept");

  // status code never 3
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:62] != 2'd3))
    else $error("bad status");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");

endmodule

bind convex_hull_trick_min_dp cht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
